// ===== hw/rtl/sey_pkg.sv =====
// Shared types, register indexes and constant functions of the secondary yield block.
`default_nettype none

package sey_pkg;

    // Configuration register indexes and reset values
    localparam int unsigned C_CFG_IDX_W = 2;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_PEAK_YIELD       = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_PEAK_ENERGY      = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_THRESHOLD_ENERGY = 2'd2;

    localparam logic [15:0] C_RST_PEAK_YIELD       = 16'd4096;
    localparam logic [23:0] C_RST_PEAK_ENERGY      = 24'd102400;
    localparam logic [23:0] C_RST_THRESHOLD_ENERGY = 24'd3200;

    typedef struct packed {
        logic signed [39:0] particle_flux;
        logic [23:0]        face_area;
        logic [23:0]        mean_energy;
    } t_in;

    typedef struct packed {
        logic [47:0] emitted_flux;
        logic [15:0] secondary_yield;
        logic        config_error;
    } t_out;

    typedef struct packed {
        logic [15:0] peak_yield;
        logic [23:0] peak_energy;
        logic [23:0] threshold_energy;
    } t_cfg;

    // Bitwise integer square root, truncated
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] xr;
        logic [63:0] r;
        logic [63:0] b;
        xr = x;
        r  = 64'd0;
        b  = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (xr >= r + b) begin
                xr = xr - (r + b);
                r  = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-2^-j) in Q30, built by repeated truncated square roots from one half
    function automatic logic [63:0] root_at(input int j);
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int k = 1; k <= 16; k++) begin
            if (k <= j) begin
                r = isqrt64(r << 30);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sey_log2.sv =====
// Pipelined log2 of a 24-bit integer in Q16: normalize, then sixteen squaring stages.
`default_nettype none

module sey_log2 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [23:0] i_n,
    output logic [20:0] o_log
);
    import sey_pkg::*;

    logic [30:0] r_m [0:16];
    logic [15:0] r_f [0:16];
    logic [4:0]  r_p [0:16];

    logic [4:0]  w_p;
    logic [4:0]  w_sh;

    // Locate the leading one
    always_comb begin
        w_p = 5'd0;
        for (int k = 0; k < 24; k++) begin
            if (i_n[k]) begin
                w_p = 5'(k);
            end
        end
        w_sh = 5'd30 - w_p;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= 31'(i_n) << w_sh;
            r_f[0] <= 16'd0;
            r_p[0] <= w_p;
        end
    end

    for (genvar i = 0; i < 16; i++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_t;
        assign w_sq = r_m[i] * r_m[i];
        assign w_t  = w_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[i+1] <= w_t[31] ? w_t[31:1] : w_t[30:0];
                r_f[i+1] <= r_f[i] | (16'(w_t[31]) << (15 - i));
                r_p[i+1] <= r_p[i];
            end
        end
    end

    assign o_log = {r_p[16], r_f[16]};

endmodule

`default_nettype wire

// ===== hw/rtl/sey_core.sv =====
// Yield and emitted flux datapath: a 92-stage pipeline with one valid bit per stage.
`default_nettype none

module sey_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sey_pkg::t_in  i_data,
    input  sey_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output sey_pkg::t_out o_data
);
    import sey_pkg::*;

    localparam int unsigned C_DEPTH = 92;
    localparam logic [6:0]  C_SH_TAIL = 7'd33;
    localparam logic [6:0]  C_SH_BODY = 7'd30;
    localparam logic signed [18:0] C_LOG2E = 19'sd94548;
    localparam logic signed [15:0] C_KTAIL = -16'sd22938;
    localparam logic signed [16:0] C_KLOW  = 17'sd36700;
    localparam logic signed [16:0] C_KHIGH = 17'sd16384;

    typedef struct packed {
        logic        below;
        logic        tail;
        logic        klow;
        logic        fpos;
        logic [38:0] flux;
        logic [23:0] area;
    } t_sa;

    typedef struct packed {
        logic [23:0] num;
        t_sa         s;
    } t_s1;

    typedef struct packed {
        logic [39:0] rem;
        logic [17:0] q;
    } t_dv;

    typedef struct packed {
        logic signed [21:0] lv;
        logic signed [19:0] t;
        t_sa                s;
    } t_b;

    typedef struct packed {
        logic signed [21:0] lv;
        logic signed [37:0] pt;
        logic signed [37:0] ptail;
        t_sa                s;
    } t_c;

    typedef struct packed {
        logic signed [23:0] l;
        logic signed [21:0] xt;
        t_sa                s;
    } t_d;

    typedef struct packed {
        logic signed [40:0] lk;
        logic signed [21:0] xt;
        t_sa                s;
    } t_e;

    typedef struct packed {
        logic [30:0] m;
        logic [15:0] frac;
        logic        ipbig;
        logic [4:0]  sh;
        t_sa         s;
    } t_xp;

    typedef struct packed {
        logic [50:0] prod;
        logic [6:0]  shamt;
        logic        zero;
        t_sa         s;
    } t_g;

    typedef struct packed {
        logic [15:0] y;
        t_sa         s;
    } t_h;

    typedef struct packed {
        logic [58:0] p;
        logic [23:0] area;
        logic [15:0] y;
    } t_i;

    typedef struct packed {
        logic [58:0] rem;
        logic [47:0] q;
        logic [23:0] area;
        logic        ovf;
        logic [15:0] y;
    } t_ed;

    // Signed Q16 to integer, rounding toward zero
    function automatic logic signed [40:0] trunc_q16(input logic signed [40:0] v);
        return (v + (v[40] ? 41'sd65535 : 41'sd0)) >>> 16;
    endfunction

    logic [C_DEPTH-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[C_DEPTH-2:0], i_valid};
        end
    end

    // Configuration must be held static by the user while items are in flight; the block does not enforce it
    logic [23:0] w_den;
    logic        w_cfg_err;
    assign w_den     = i_cfg.peak_energy - i_cfg.threshold_energy;
    assign w_cfg_err = i_cfg.peak_energy <= i_cfg.threshold_energy;

    // Entry stage
    t_s1         r_s1;
    t_s1         n_s1;
    logic [23:0] w_num;

    always_comb begin
        w_num          = i_data.mean_energy - i_cfg.threshold_energy;
        n_s1.num       = w_num;
        n_s1.s.below   = i_data.mean_energy <= i_cfg.threshold_energy;
        n_s1.s.tail    = (30'(w_num) * 30'd10) > (30'(w_den) * 30'd36);
        n_s1.s.klow    = w_num < w_den;
        n_s1.s.fpos    = !i_data.particle_flux[39] && (i_data.particle_flux[38:0] != '0)
                         && (i_data.face_area != '0);
        n_s1.s.flux    = i_data.particle_flux[38:0];
        n_s1.s.area    = i_data.face_area;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    // Log2 lanes for numerator and denominator
    logic [20:0] w_lnum;
    logic [20:0] w_lden;
    logic [20:0] r_lnum;
    logic [20:0] r_lden;

    sey_log2 u_log_num (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_n   (r_s1.num),
        .o_log (w_lnum)
    );

    sey_log2 u_log_den (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_n   (w_den),
        .o_log (w_lden)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lnum <= w_lnum;
            r_lden <= w_lden;
        end
    end

    // Quotient num/den in Q16, one bit per stage
    t_dv r_dv   [0:17];
    t_sa r_sa   [0:17];
    t_dv w_dv_in [0:17];
    t_sa w_sa_in [0:17];

    assign w_dv_in[0] = '{rem: {r_s1.num, 16'd0}, q: 18'd0};
    assign w_sa_in[0] = r_s1.s;

    for (genvar i = 0; i < 18; i++) begin : g_vq
        localparam int unsigned B = 17 - i;
        logic [41:0] w_dsh;
        logic        w_ge;
        t_dv         n_dv;

        if (i > 0) begin : g_link
            assign w_dv_in[i] = r_dv[i-1];
            assign w_sa_in[i] = r_sa[i-1];
        end

        assign w_dsh = {18'd0, w_den} << B;
        assign w_ge  = {2'b00, w_dv_in[i].rem} >= w_dsh;

        always_comb begin
            n_dv      = w_dv_in[i];
            n_dv.rem  = w_ge ? w_dv_in[i].rem - w_dsh[39:0] : w_dv_in[i].rem;
            n_dv.q[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[i] <= n_dv;
                r_sa[i] <= w_sa_in[i];
            end
        end
    end

    // Exponent arithmetic
    t_b r_b;
    t_c r_c;
    t_d r_d;
    t_e r_e;
    t_xp r_f;
    t_b n_b;
    t_c n_c;
    t_d n_d;
    t_e n_e;
    t_xp n_f;

    logic signed [40:0] w_corr_f;
    logic signed [40:0] w_xt_f;
    logic signed [21:0] w_xt;
    logic signed [23:0] w_lc;
    logic signed [16:0] w_k;
    logic signed [40:0] w_x_f;
    logic signed [25:0] w_xsel;
    logic [25:0]        w_a;

    always_comb begin
        n_b.lv = $signed({1'b0, r_lnum}) - $signed({1'b0, r_lden});
        n_b.t  = 20'sd65536 - $signed({2'b00, r_dv[17].q});
        n_b.s  = r_sa[17];

        n_c.lv    = r_b.lv;
        n_c.pt    = r_b.t * C_LOG2E;
        n_c.ptail = r_b.lv * C_KTAIL;
        n_c.s     = r_b.s;

        w_corr_f = trunc_q16(41'(r_c.pt));
        w_xt_f   = trunc_q16(41'(r_c.ptail));
        w_xt     = $signed(w_xt_f[21:0]);
        n_d.l    = 24'(r_c.lv) + $signed(w_corr_f[23:0]);
        n_d.xt   = (w_xt > 22'sd0) ? 22'sd0 : w_xt;
        n_d.s    = r_c.s;

        w_lc   = (r_d.l > 24'sd0) ? 24'sd0 : r_d.l;
        w_k    = r_d.s.klow ? C_KLOW : C_KHIGH;
        n_e.lk = w_lc * w_k;
        n_e.xt = r_d.xt;
        n_e.s  = r_d.s;

        w_x_f     = trunc_q16(r_e.lk);
        w_xsel    = r_e.s.tail ? 26'(r_e.xt) : $signed(w_x_f[25:0]);
        w_a       = 26'(-w_xsel);
        n_f.m     = 31'd1 << 30;
        n_f.frac  = w_a[15:0];
        n_f.ipbig = w_a[25:16] >= 10'd31;
        n_f.sh    = w_a[20:16];
        n_f.s     = r_e.s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            r_f <= n_f;
        end
    end

    // Fractional power of two: one root factor per stage
    t_xp r_x   [0:15];
    t_xp w_x_in [0:15];

    assign w_x_in[0] = r_f;

    for (genvar j = 0; j < 16; j++) begin : g_exp
        localparam logic [63:0] C_ROOT64 = root_at(j + 1);
        localparam logic [30:0] C_ROOT   = C_ROOT64[30:0];
        logic [61:0] w_p;
        t_xp         n_x;

        if (j > 0) begin : g_link
            assign w_x_in[j] = r_x[j-1];
        end

        assign w_p = w_x_in[j].m * C_ROOT;

        always_comb begin
            n_x = w_x_in[j];
            if (w_x_in[j].frac[15-j]) begin
                n_x.m = w_p[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j] <= n_x;
            end
        end
    end

    // Scale by peak yield, shift, saturate, then form the emitted flux product
    t_g  r_g;
    t_h  r_h;
    t_i  r_i;
    t_g  n_g;
    t_h  n_h;
    t_i  n_i;
    t_ed n_j;

    logic [19:0] w_dm;
    logic [50:0] w_sy;
    logic [54:0] w_fy;

    always_comb begin
        w_dm       = r_x[15].s.tail ? 20'(i_cfg.peak_yield) * 20'd9 : 20'(i_cfg.peak_yield);
        n_g.prod   = w_dm * r_x[15].m;
        n_g.shamt  = (r_x[15].s.tail ? C_SH_TAIL : C_SH_BODY) + 7'(r_x[15].sh);
        n_g.zero   = r_x[15].s.below | r_x[15].ipbig;
        n_g.s      = r_x[15].s;

        w_sy = r_g.prod >> r_g.shamt;
        if (r_g.zero || w_cfg_err) begin
            n_h.y = 16'd0;
        end else if (w_sy > 51'd65535) begin
            n_h.y = 16'hFFFF;
        end else begin
            n_h.y = w_sy[15:0];
        end
        n_h.s = r_g.s;

        w_fy     = r_h.s.flux * r_h.y;
        n_i.p    = r_h.s.fpos ? {w_fy, 4'd0} : 59'd0;
        n_i.area = r_h.s.area;
        n_i.y    = r_h.y;

        n_j.rem  = r_i.p;
        n_j.q    = 48'd0;
        n_j.area = r_i.area;
        n_j.ovf  = (r_i.area != '0) && ({13'd0, r_i.p} >= {r_i.area, 48'd0});
        n_j.y    = r_i.y;
    end

    t_ed r_j;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g <= n_g;
            r_h <= n_h;
            r_i <= n_i;
            r_j <= n_j;
        end
    end

    // Emitted flux quotient, one bit per stage
    t_ed r_ed    [0:47];
    t_ed w_ed_in [0:47];

    assign w_ed_in[0] = r_j;

    for (genvar i = 0; i < 48; i++) begin : g_ediv
        localparam int unsigned B = 47 - i;
        logic [71:0] w_ash;
        logic        w_ge;
        t_ed         n_ed;

        if (i > 0) begin : g_link
            assign w_ed_in[i] = r_ed[i-1];
        end

        assign w_ash = {48'd0, w_ed_in[i].area} << B;
        assign w_ge  = {13'd0, w_ed_in[i].rem} >= w_ash;

        always_comb begin
            n_ed      = w_ed_in[i];
            n_ed.rem  = w_ge ? w_ed_in[i].rem - w_ash[58:0] : w_ed_in[i].rem;
            n_ed.q[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ed[i] <= n_ed;
            end
        end
    end

    // A zero area leaves the quotient bits meaningless; force zero flux there
    assign o_valid                = r_v[C_DEPTH-1];
    assign o_data.emitted_flux    = r_ed[47].ovf ? '1 :
                                    ((r_ed[47].area == '0) ? '0 : r_ed[47].q);
    assign o_data.secondary_yield = r_ed[47].y;
    assign o_data.config_error    = w_cfg_err;

endmodule

`default_nettype wire

// ===== hw/rtl/secondary_electron_yield_flux.sv =====
// Top level of the secondary electron yield block: config registers, datapath, output skid.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------------------
//  input   | i_in_valid | o_in_ready  | i_in_data  (flux, area, mean energy)
//  output  | o_out_valid| i_out_ready | o_out_data (emitted flux, yield, error)
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One transfer per cycle sustained while the skid register is empty. A result passes
//  the core pipeline, mostly the two bit-per-stage dividers and the sixteen squaring
//  and root-factor stages, then the output register. Reset is synchronous active low
//  and clears valid bits and config registers. A stall at the output freezes the
//  whole pipeline only once the skid register is also full; inputs are taken until then.
`default_nettype none

module secondary_electron_yield_flux (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sey_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sey_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sey_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [23:0]                      i_cfg_data
);
    import sey_pkg::*;

    // Configuration registers; writes are always taken
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_yield       <= C_RST_PEAK_YIELD;
            r_cfg.peak_energy      <= C_RST_PEAK_ENERGY;
            r_cfg.threshold_energy <= C_RST_THRESHOLD_ENERGY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                C_CFG_PEAK_YIELD:       r_cfg.peak_yield       <= i_cfg_data[15:0];
                C_CFG_PEAK_ENERGY:      r_cfg.peak_energy      <= i_cfg_data;
                C_CFG_THRESHOLD_ENERGY: r_cfg.threshold_energy <= i_cfg_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Pipeline advances whenever the skid register is empty
    logic  r_out_v;
    logic  r_skid_v;
    t_out  r_out;
    t_out  r_skid;
    logic  w_en;
    logic  w_core_v;
    t_out  w_core_d;

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    sey_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_core_v),
        .o_data  (w_core_d)
    );

    // Output register plus skid: hold a result while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_core_v) begin
            if (!r_out_v || i_out_ready) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (w_core_v) begin
            if (!r_out_v || i_out_ready) begin
                r_out <= w_core_d;
            end else begin
                r_skid <= w_core_d;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A result in the skid implies one waits in the output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result with the output register empty");

    // Bad configuration forces both numeric fields to zero
    a_cfg_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.config_error) |->
        (o_out_data.emitted_flux == '0 && o_out_data.secondary_yield == '0))
        else $error("config error with nonzero result");

    // No yield means no emitted flux
    a_zero_yield_zero_flux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.secondary_yield == '0) |->
        (o_out_data.emitted_flux == '0))
        else $error("emitted flux without yield");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_secondary_electron_yield_flux.sv =====
// Self-checking testbench of the secondary electron yield block: directed table, bad settings, then random phases.
`default_nettype none

module tb_secondary_electron_yield_flux;
    import sey_pkg::*;

    // Pipeline depth plus margin; idle wait before a register write and at the end
    localparam int C_DRAIN   = 120;
    localparam int C_WD_MAX  = 3000;
    localparam int C_N_RAND  = 1850;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in                    i_in_data;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out                   o_out_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [C_CFG_IDX_W-1:0] i_cfg_index;
    logic [23:0]            i_cfg_data;

    secondary_electron_yield_flux dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Yield predictor: own copy of the registers and the root-factor table
    // ------------------------------------------------------------------
    logic [15:0] yld_peak;
    logic [23:0] yld_emax;
    logic [23:0] yld_e0;
    longint unsigned half_roots [17];

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned rem, root, bitv;
        rem  = x;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // log2 in Q16 by normalize-and-square, truncated
    function automatic longint log2_fix(input longint unsigned n);
        int p;
        longint unsigned m;
        longint acc;
        p = 0;
        while (p < 23 && (n >> (p + 1)) != 0) p++;
        m   = n << (30 - p);
        acc = longint'(p) * 65536;
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m   = m >> 1;
                acc = acc + (longint'(1) << (16 - i));
            end
        end
        return acc;
    endfunction

    // 2^-a, a in Q16: Q30 mantissa plus integer shift
    function automatic longint unsigned pow2_neg(input longint unsigned a, output int sh);
        longint unsigned m, ip;
        m  = 64'd1 << 30;
        ip = a >> 16;
        for (int j = 1; j <= 16; j++)
            if ((a >> (16 - j)) & 1) m = (m * half_roots[j]) >> 30;
        sh = (ip >= 31) ? 31 : int'(ip);
        return (ip >= 31) ? 64'd0 : m;
    endfunction

    function automatic logic [15:0] vaughan_yield(input logic [23:0] e);
        longint unsigned num, den, m, y;
        longint lv, x, vq, l, k;
        int sh;
        if (e <= yld_e0) return 16'd0;
        num = e - yld_e0;
        den = yld_emax - yld_e0;
        lv  = log2_fix(num) - log2_fix(den);
        if (num * 10 > den * 36) begin
            x = (longint'(-22938) * lv) / 65536;
            if (x > 0) x = 0;
            m = pow2_neg(longint'(-x), sh);
            y = (longint'(yld_peak) * 9 * m) >> (33 + sh);
        end else begin
            vq = longint'((num << 16) / den);
            l  = lv + ((65536 - vq) * 94548) / 65536;
            k  = (num < den) ? 36700 : 16384;
            if (l > 0) l = 0;
            x = (l * k) / 65536;
            m = pow2_neg(longint'(-x), sh);
            y = (longint'(yld_peak) * m) >> (30 + sh);
        end
        return (y > 65535) ? 16'hFFFF : y[15:0];
    endfunction

    function automatic t_out predict_face(input t_in f);
        t_out r;
        longint unsigned emit;
        r = '0;
        if (yld_emax <= yld_e0) begin
            r.config_error = 1'b1;
            return r;
        end
        r.secondary_yield = vaughan_yield(f.mean_energy);
        if (f.particle_flux > 0 && f.face_area != 0) begin
            emit = (longint'(f.particle_flux) * r.secondary_yield * 16) / f.face_area;
            r.emitted_flux = (emit > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : emit[47:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    t_out pending_faces [$];
    int   mismatches;
    int   idle_cycles;
    logic cur_typed;
    t_out cur_exp;

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pending_faces.push_back(cur_typed ? cur_exp : predict_face(i_in_data));
            if (o_out_valid && i_out_ready) begin
                if (pending_faces.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", o_out_data);
                end else begin
                    want = pending_faces.pop_front();
                    if (want.emitted_flux !== o_out_data.emitted_flux ||
                        want.secondary_yield !== o_out_data.secondary_yield ||
                        want.config_error !== o_out_data.config_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp emit=%0d yield=%0d err=%0b",
                                     want.emitted_flux, want.secondary_yield,
                                     want.config_error,
                                     " got emit=%0d yield=%0d err=%0b",
                                     o_out_data.emitted_flux, o_out_data.secondary_yield,
                                     o_out_data.config_error);
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    initial begin
        wait (idle_cycles >= C_WD_MAX);
        $display("FAIL secondary_electron_yield_flux");
        $finish;
    end

    // Receiver: rotate through four stall styles: always ready, random, periodic, mostly ready
    int unsigned rx_cycle;
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 300) % 4)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                i_out_ready <= ((rx_cycle % 37) > 25);
            end
            default: begin
                i_out_ready <= ($urandom_range(0, 9) < 8);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int burst_left;

    task automatic send_face(input t_in f, input logic typed, input t_out exp_out);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        cur_typed  <= typed;
        cur_exp    <= exp_out;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, let every expected result arrive, then drain the pipe
    task automatic settle;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_faces.size() != 0) @(posedge i_clk);
        repeat (C_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            C_CFG_PEAK_YIELD:       yld_peak = val[15:0];
            C_CFG_PEAK_ENERGY:      yld_emax = val;
            C_CFG_THRESHOLD_ENERGY: yld_e0   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_cfg(input logic [23:0] py, input logic [23:0] pe, input logic [23:0] th);
        settle();
        write_reg(C_CFG_PEAK_YIELD, py);
        write_reg(C_CFG_PEAK_ENERGY, pe);
        write_reg(C_CFG_THRESHOLD_ENERGY, th);
    endtask

    // Random face; energy mostly placed around the curve of the current setting
    function automatic t_in rand_face();
        t_in f;
        longint unsigned den, e;
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       f.particle_flux = r64[39:0];
            1:       f.particle_flux = -40'($signed({1'b0, r64[19:0]}));
            2:       f.particle_flux = (r64[0]) ? 40'sh7F_FFFF_FFFF : 40'sh0;
            3:       f.particle_flux = {1'b0, r64[38:0]};
            default: f.particle_flux = {20'd0, r64[19:0]};
        endcase
        case ($urandom_range(0, 5))
            0:       f.face_area = 24'd0;
            1:       f.face_area = 24'hFFFFFF;
            2:       f.face_area = 24'($urandom_range(1, 255));
            default: f.face_area = 24'($urandom);
        endcase
        den = (yld_emax > yld_e0) ? yld_emax - yld_e0 : 1;
        if ($urandom_range(0, 3) == 0) begin
            f.mean_energy = 24'($urandom);
        end else begin
            e = yld_e0 + (den * $urandom_range(0, 8192)) / 1024;
            f.mean_energy = (e > 24'hFFFFFF) ? 24'hFFFFFF : e[23:0];
        end
        return f;
    endfunction

    typedef struct {
        t_in  face;
        logic typed;
        t_out exp_out;
    } t_row;

    t_row table_rows [$];

    function automatic t_row row(input logic signed [39:0] fl, input logic [23:0] ar,
                                 input logic [23:0] en, input logic typed,
                                 input logic [47:0] em, input logic [15:0] yv);
        t_row r;
        r.face.particle_flux = fl;
        r.face.face_area     = ar;
        r.face.mean_energy   = en;
        r.typed   = typed;
        r.exp_out = '{emitted_flux: em, secondary_yield: yv, config_error: 1'b0};
        return r;
    endfunction

    initial begin
        t_out none;
        none = '0;
        half_roots[0] = 64'd1 << 29;
        for (int j = 1; j <= 16; j++) half_roots[j] = floor_sqrt(half_roots[j - 1] << 30);
        yld_peak = C_RST_PEAK_YIELD;
        yld_emax = C_RST_PEAK_ENERGY;
        yld_e0   = C_RST_THRESHOLD_ENERGY;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        rx_cycle    = 0;
        cur_typed   = 1'b0;
        cur_exp     = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = C_CFG_PEAK_YIELD;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset settings (E0 12.5 eV, Emax 400 eV, unit peak)
        table_rows.push_back(row(40'sh7F_FFFF_FFFF, 24'd1, 24'd0, 1'b1, 48'd0, 16'd0));
        table_rows.push_back(row(-40'sh80_0000_0000, 24'hFFFFFF, 24'd3200, 1'b1, 48'd0, 16'd0));
        table_rows.push_back(row(40'sd1, 24'd65536, 24'd102400, 1'b1, 48'd1, 16'd4096));
        table_rows.push_back(row(40'sd0, 24'hFFFFFF, 24'd102400, 1'b1, 48'd0, 16'd4096));
        table_rows.push_back(row(40'sd1000, 24'd0, 24'd102400, 1'b1, 48'd0, 16'd4096));
        table_rows.push_back(row(40'sd12345, 24'd1, 24'd102400, 1'b1, 48'd809041920, 16'd4096));
        table_rows.push_back(row(40'sh7F_FFFF_FFFF, 24'd1, 24'hFFFFFF, 1'b0, 48'd0, 16'd0));
        table_rows.push_back(row(40'sd777, 24'd300, 24'd3201, 1'b0, 48'd0, 16'd0));
        table_rows.push_back(row(40'sd99999, 24'd65536, 24'd20000, 1'b0, 48'd0, 16'd0));
        table_rows.push_back(row(40'sd99999, 24'd65536, 24'd400000, 1'b0, 48'd0, 16'd0));
        table_rows.push_back(row(40'sd99999, 24'd65536, 24'd360320, 1'b0, 48'd0, 16'd0));
        table_rows.push_back(row(-40'sd1, 24'd1, 24'd50000, 1'b0, 48'd0, 16'd0));
        table_rows.push_back(row(40'sh7F_FFFF_FFFF, 24'hFFFFFF, 24'd200000, 1'b0, 48'd0, 16'd0));
        foreach (table_rows[i]) send_face(table_rows[i].face, table_rows[i].typed,
                                          table_rows[i].exp_out);

        // Bad settings: Emax equal to and below E0 flag an error
        set_cfg(24'd4096, 24'd5000, 24'd5000);
        for (int i = 0; i < 4; i++) send_face(rand_face(), 1'b0, none);
        set_cfg(24'd4096, 24'd0, 24'hFFFFFF);
        for (int i = 0; i < 4; i++) send_face(rand_face(), 1'b0, none);

        // Random phases over several settings, extremes first
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_cfg(24'd1, 24'hFFFFFF, 24'd0);
                1: set_cfg(24'hFFFFFF, 24'd102400, 24'd3200);
                2: set_cfg(24'd4096, 24'd3201, 24'd3200);
                3: set_cfg(24'd65535, 24'hFFFFFF, 24'hFFFFFE);
                4: set_cfg(24'd8192, 24'd256, 24'd0);
                5: set_cfg(C_RST_PEAK_YIELD, C_RST_PEAK_ENERGY, C_RST_THRESHOLD_ENERGY);
                default: set_cfg(24'($urandom), 24'($urandom),
                                 24'($urandom_range(0, 24'h3FFFFF)));
            endcase
            for (int i = 0; i < C_N_RAND / 10; i++) send_face(rand_face(), 1'b0, none);
        end

        settle();
        if (mismatches == 0 && pending_faces.size() == 0) begin
            $display("PASS secondary_electron_yield_flux");
        end else begin
            $display("FAIL secondary_electron_yield_flux");
        end
        $finish;
    end

endmodule

`default_nettype wire
